// ===== rtl/sn2d_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sn2d_pkg
// Shared types, constants and actions of the 2D simplex noise block.
// ----------------------------------------------------------------------------
package sn2d_pkg;

  // Table geometry and coordinate format.
  localparam int unsigned TableSize     = 256;
  localparam int unsigned CoordFracBits = 16;

  // Skew and unskew factors in unsigned Q0.32.
  localparam logic [31:0] SkewQ32   = 32'd1572067139;
  localparam logic [31:0] UnskewQ32 = 32'd907633386;
  // Unskew factor rounded to Q.24.
  localparam logic signed [27:0] UnskewQ24 = 28'sd3545443;
  localparam logic signed [27:0] OneQ24    = 28'sd16777216;
  localparam logic [6:0]         Scale     = 7'd70;

  // Actions carried by an input item.
  typedef enum logic [1:0] {
    ActEval     = 2'd0,
    ActLoadPerm = 2'd1,
    ActLoadGrad = 2'd2,
    ActNone     = 2'd3
  } action_e;

endpackage
`default_nettype wire

// ===== rtl/sn2d_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sn2d_in_if
// Input channel: valid/ready handshake with one evaluate or table load item.
// ----------------------------------------------------------------------------
interface sn2d_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [31:0]        x_coord;
  logic [31:0]        y_coord;
  logic [7:0]         table_index;
  logic [7:0]         perm_value;
  logic signed [15:0] grad_x;
  logic signed [15:0] grad_y;

  modport source (output valid, action, x_coord, y_coord, table_index, perm_value,
                  grad_x, grad_y, input ready);
  modport sink   (input valid, action, x_coord, y_coord, table_index, perm_value,
                  grad_x, grad_y, output ready);
endinterface
`default_nettype wire

// ===== rtl/sn2d_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sn2d_out_if
// Output channel: valid/ready handshake carrying one noise value.
// ----------------------------------------------------------------------------
interface sn2d_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] noise_value;

  modport source (output valid, noise_value, input ready);
  modport sink   (input valid, noise_value, output ready);
endinterface
`default_nettype wire

// ===== rtl/simplex_noise_2d_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// simplex_noise_2d_top
// 2D simplex noise over loadable permutation and gradient tables.
// ----------------------------------------------------------------------------
// Every input item is a table load, an evaluate or no action. An evaluate
// gives one signed Q1.15 noise value; the others give nothing. The pipeline
// takes one item per cycle when the output is not stalled. The permutation
// table is read in two rounds (three corner rows, then three hashed entries),
// each through replicated single-read registered memories, then the gradient
// memories. Tables must be loaded before they are read. A load travels down
// the pipeline with the evaluates and writes each memory copy at the stage
// that reads it, so every evaluate sees exactly the loads that were
// transferred before it. The whole pipeline stalls only when the output
// register holds a result that is not taken, so ready stays high otherwise.
// ----------------------------------------------------------------------------

// Falloff and gradient arithmetic of one corner, five register stages deep.
module sn2d_corner (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic signed [27:0] dx_i,
  input  wire logic signed [27:0] dy_i,
  input  wire logic [31:0]        grad_i,
  output logic signed [63:0]      contr_o
);
  logic signed [55:0] a_dxx_q, a_dyy_q;
  logic signed [43:0] a_gx_q, a_gy_q;
  logic signed [57:0] tw;
  logic               b_zero_q, c_zero_q, d_zero_q;
  logic [23:0]        b_t24_q;
  logic [22:0]        c_t2_q;
  logic [20:0]        d_t4_q;
  logic signed [29:0] b_dot_q, c_dot_q, d_dot_q;

  // Half minus the squared distance, in Q.48.
  always_comb tw = (58'sd1 <<< 47) - (58'(a_dxx_q) + 58'(a_dyy_q));

  // Squares and products first, then the falloff is squared twice.
  always_ff @(posedge clk_i) if (en_i) begin
    a_dxx_q  <= 56'(dx_i) * 56'(dx_i);
    a_dyy_q  <= 56'(dy_i) * 56'(dy_i);
    a_gx_q   <= 44'($signed(grad_i[15:0])) * 44'(dx_i);
    a_gy_q   <= 44'($signed(grad_i[31:16])) * 44'(dy_i);
    b_zero_q <= tw[57];
    b_t24_q  <= 24'(tw >>> 24);
    b_dot_q  <= 30'((45'(a_gx_q) + 45'(a_gy_q)) >>> 15);
    c_zero_q <= b_zero_q;
    c_dot_q  <= b_dot_q;
    c_t2_q   <= 23'((48'(b_t24_q) * 48'(b_t24_q)) >> 24);
    d_zero_q <= c_zero_q;
    d_dot_q  <= c_dot_q;
    d_t4_q   <= 21'((46'(c_t2_q) * 46'(c_t2_q)) >> 24);
    contr_o  <= d_zero_q ? 64'sd0
                         : 64'(52'($signed({1'b0, d_t4_q})) * 52'(d_dot_q));
  end
endmodule

module simplex_noise_2d_top #(
  parameter int unsigned TableSize     = sn2d_pkg::TableSize,
  parameter int unsigned CoordFracBits = sn2d_pkg::CoordFracBits
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sn2d_in_if.sink    in_i,
  sn2d_out_if.source out_o
);
  localparam int unsigned Aw = $clog2(TableSize);
  localparam int unsigned Ns = 14;

  // Stage valid bits and a global enable; stall only on a held result.
  logic [Ns-1:0] v_q;
  logic          en;
  logic          outv_q;
  logic signed [15:0] out_q;
  assign en = !(outv_q && !out_o.ready);
  assign in_i.ready = en;
  assign out_o.valid = outv_q;
  assign out_o.noise_value = out_q;

  wire acc = in_i.valid && en;
  wire is_eval = (in_i.action == sn2d_pkg::ActEval);

  // Load transfers follow the pipeline: flags, index and data per stage.
  logic [4:0]  ldp_q;
  logic [5:0]  ldg_q;
  logic [7:0]  ld_idx_q [6];
  logic [31:0] ld_dat_q [6];
  always_ff @(posedge clk_i) if (en) begin
    ld_idx_q[0] <= in_i.table_index;
    ld_dat_q[0] <= (in_i.action == sn2d_pkg::ActLoadPerm) ? {24'd0, in_i.perm_value}
                                                         : {in_i.grad_y, in_i.grad_x};
    for (int k = 1; k < 6; k++) begin
      ld_idx_q[k] <= ld_idx_q[k-1];
      ld_dat_q[k] <= ld_dat_q[k-1];
    end
  end

  // Memories: three copies of the permutation table per read round, and
  // three gradient copies. Each is written at the stage that reads it.
  logic [7:0]  perm_a [3][TableSize];
  logic [7:0]  perm_b [3][TableSize];
  logic [31:0] grad_m [3][TableSize];

  always_ff @(posedge clk_i) begin
    if (en && ldp_q[2]) begin
      for (int k = 0; k < 3; k++) perm_a[k][Aw'(ld_idx_q[2])] <= ld_dat_q[2][7:0];
    end
    if (en && ldp_q[4]) begin
      for (int k = 0; k < 3; k++) perm_b[k][Aw'(ld_idx_q[4])] <= ld_dat_q[4][7:0];
    end
    if (en && ldg_q[5]) begin
      for (int k = 0; k < 3; k++) grad_m[k][Aw'(ld_idx_q[5])] <= ld_dat_q[5];
    end
  end

  // Stage 0: register the point.
  logic [32:0] s0_sum_q;
  logic [31:0] s0_x_q, s0_y_q;
  always_ff @(posedge clk_i) if (en) begin
    s0_x_q <= in_i.x_coord;
    s0_y_q <= in_i.y_coord;
    s0_sum_q <= {1'b0, in_i.x_coord} + {1'b0, in_i.y_coord};
  end

  // Stage 1: skew product t = floor(sum*F2).
  logic [31:0] s1_x_q, s1_y_q, s1_t_q;
  always_ff @(posedge clk_i) if (en) begin
    s1_x_q <= s0_x_q;
    s1_y_q <= s0_y_q;
    s1_t_q <= 32'((65'(s0_sum_q) * 65'(sn2d_pkg::SkewQ32)) >> 32);
  end

  // Stage 2: cell indices.
  localparam int unsigned Iw = 33 - CoordFracBits;
  logic [31:0] s2_x_q, s2_y_q;
  logic [Iw-1:0] s2_i_q, s2_j_q;
  always_ff @(posedge clk_i) if (en) begin
    s2_x_q <= s1_x_q;
    s2_y_q <= s1_y_q;
    s2_i_q <= Iw'(({1'b0, s1_x_q} + {1'b0, s1_t_q}) >> CoordFracBits);
    s2_j_q <= Iw'(({1'b0, s1_y_q} + {1'b0, s1_t_q}) >> CoordFracBits);
  end

  // Stage 3: unskew term (i+j)*G2, issue first permutation reads.
  logic signed [66:0] s3_back_q;
  logic [31:0] s3_x_q, s3_y_q;
  logic [Iw-1:0] s3_i_q, s3_j_q;
  logic [7:0] s3_pj0_q, s3_pj1_q, s3_pj2_q;
  always_ff @(posedge clk_i) if (en) begin
    s3_x_q <= s2_x_q;
    s3_y_q <= s2_y_q;
    s3_i_q <= s2_i_q;
    s3_j_q <= s2_j_q;
    s3_back_q <= 67'(({1'b0, s2_i_q} + {1'b0, s2_j_q}) * 64'(sn2d_pkg::UnskewQ32));
    s3_pj0_q <= perm_a[0][Aw'(s2_j_q)];
    s3_pj1_q <= perm_a[1][Aw'(s2_j_q + Iw'(1))];
    s3_pj2_q <= perm_a[2][Aw'(s2_j_q + Iw'(1))];
  end

  // Stage 4: offsets of the first corner in Q.24 (floored) and triangle.
  logic signed [66:0] x0w, y0w;
  logic signed [27:0] s4_x0_q, s4_y0_q;
  logic [Iw-1:0] s4_i_q;
  logic [7:0] s4_pj0_q, s4_pj1_q, s4_pj2_q;
  always_comb begin
    x0w = ($signed(67'(s3_x_q)) <<< (32 - CoordFracBits))
          - ($signed(67'(s3_i_q)) <<< 32) + s3_back_q;
    y0w = ($signed(67'(s3_y_q)) <<< (32 - CoordFracBits))
          - ($signed(67'(s3_j_q)) <<< 32) + s3_back_q;
  end
  always_ff @(posedge clk_i) if (en) begin
    s4_x0_q <= 28'(x0w >>> 8);
    s4_y0_q <= 28'(y0w >>> 8);
    s4_i_q <= s3_i_q;
    s4_pj0_q <= s3_pj0_q;
    s4_pj1_q <= s3_pj1_q;
    s4_pj2_q <= s3_pj2_q;
  end

  // Stage 5: corner offsets and second permutation reads.
  wire up = (s4_x0_q > s4_y0_q);
  logic signed [27:0] s5_dx_q [3], s5_dy_q [3];
  logic [7:0] s5_g_q [3];
  wire [7:0] pjm = (up ? s4_pj0_q : s4_pj1_q);
  // Note: with i1=1,j1=0 row is perm[pj]; with i1=0,j1=1 row is perm[pj+1].
  always_ff @(posedge clk_i) if (en) begin
    s5_dx_q[0] <= s4_x0_q;
    s5_dy_q[0] <= s4_y0_q;
    s5_dx_q[1] <= s4_x0_q - (up ? sn2d_pkg::OneQ24 : 28'sd0) + sn2d_pkg::UnskewQ24;
    s5_dy_q[1] <= s4_y0_q - (up ? 28'sd0 : sn2d_pkg::OneQ24) + sn2d_pkg::UnskewQ24;
    s5_dx_q[2] <= s4_x0_q - sn2d_pkg::OneQ24 + (sn2d_pkg::UnskewQ24 <<< 1);
    s5_dy_q[2] <= s4_y0_q - sn2d_pkg::OneQ24 + (sn2d_pkg::UnskewQ24 <<< 1);
    s5_g_q[0] <= perm_b[0][Aw'(s4_i_q + Iw'(s4_pj0_q))];
    s5_g_q[1] <= perm_b[1][Aw'(s4_i_q + Iw'(up) + Iw'(pjm))];
    s5_g_q[2] <= perm_b[2][Aw'(s4_i_q + Iw'(1) + Iw'(s4_pj2_q))];
  end

  // Stage 6: gradient reads, offsets carried alongside.
  logic signed [27:0] s6_dx_q [3], s6_dy_q [3];
  logic [31:0] s6_grad_q [3];
  always_ff @(posedge clk_i) if (en) begin
    for (int c = 0; c < 3; c++) begin
      s6_dx_q[c] <= s5_dx_q[c];
      s6_dy_q[c] <= s5_dy_q[c];
      s6_grad_q[c] <= grad_m[c][Aw'(s5_g_q[c])];
    end
  end

  // Corner lanes: falloff arithmetic.
  logic signed [63:0] lane_q [3];
  for (genvar c = 0; c < 3; c++) begin : g_lane
    sn2d_corner u_corner (
      .clk_i   (clk_i),
      .en_i    (en),
      .dx_i    (s6_dx_q[c]),
      .dy_i    (s6_dy_q[c]),
      .grad_i  (s6_grad_q[c]),
      .contr_o (lane_q[c])
    );
  end

  // Sum, scale, round and saturate over three stages.
  logic signed [65:0] sum_q;
  logic signed [73:0] scl_q;
  logic signed [40:0] vv;
  always_comb vv = 41'((scl_q + (74'sd1 <<< 32)) >>> 33);
  always_ff @(posedge clk_i) if (en) begin
    sum_q <= 66'(lane_q[0]) + 66'(lane_q[1]) + 66'(lane_q[2]);
    scl_q <= 74'(sum_q) * 74'(sn2d_pkg::Scale);
  end

  // Valid pipeline, load flags and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
      ldp_q <= '0;
      ldg_q <= '0;
      outv_q <= 1'b0;
      out_q <= '0;
    end else if (en) begin
      v_q <= {v_q[Ns-2:0], acc && is_eval};
      ldp_q <= {ldp_q[3:0], acc && (in_i.action == sn2d_pkg::ActLoadPerm)};
      ldg_q <= {ldg_q[4:0], acc && (in_i.action == sn2d_pkg::ActLoadGrad)};
      outv_q <= v_q[Ns-1];
      if (vv > 41'sd32767) out_q <= 16'sh7fff;
      else if (vv < -41'sd32768) out_q <= -16'sh8000;
      else out_q <= 16'(vv);
    end
  end
endmodule
`default_nettype wire

// ===== bench/tb_noise_checker.sv =====
// ----------------------------------------------------------------------------
// tb_noise_checker
// Watches both channels of the simplex noise block, keeps its own copy of the
// permutation and gradient tables, predicts each noise value in fixed point
// and compares every output transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_noise_checker (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sn2d_in_if        in_i,
  sn2d_out_if       out_i,
  output int        fail_count_o,
  output int        pending_o
);
  logic [7:0]  perm_mem [sn2d_pkg::TableSize];
  logic [31:0] grad_mem [sn2d_pkg::TableSize];
  logic signed [15:0] noise_q [$];

  // Arithmetic shift with floor on signed 64-bit values.
  function automatic longint floor_shr(longint v, int n);
    return v >>> n;
  endfunction

  // Contribution of one corner, in Q.48.
  function automatic longint corner_term(logic [7:0] gi, longint dx, longint dy);
    longint t, t24, t2, t4, gx, gy, dot;
    logic [31:0] g;
    t = (longint'(1) <<< 47) - (dx * dx + dy * dy);
    if (t < 0) return 0;
    t24 = t >>> 24;
    t2  = (t24 * t24) >>> 24;
    t4  = (t2 * t2) >>> 24;
    g   = grad_mem[gi];
    gx  = longint'($signed(g[15:0]));
    gy  = longint'($signed(g[31:16]));
    dot = floor_shr(gx * dx + gy * dy, 15);
    return t4 * dot;
  endfunction

  // Noise at an unsigned Q16.16 point, saturated Q1.15.
  function automatic logic signed [15:0] noise_at(logic [31:0] x, logic [31:0] y);
    logic [63:0] t, i, j;
    longint back, x0, y0, x1, y1, x2, y2, sum, v, u24;
    logic [7:0] pi, pj, g0, g1, g2;
    logic i1, j1;
    t = ((64'(x) + 64'(y)) * 64'(sn2d_pkg::SkewQ32)) >> 32;
    i = (64'(x) + t) >> sn2d_pkg::CoordFracBits;
    j = (64'(y) + t) >> sn2d_pkg::CoordFracBits;
    back = longint'((i + j) * 64'(sn2d_pkg::UnskewQ32));
    x0 = longint'(64'(x) << 16) - longint'(i << 32) + back;
    y0 = longint'(64'(y) << 16) - longint'(j << 32) + back;
    x0 = floor_shr(x0, 8);
    y0 = floor_shr(y0, 8);
    i1 = (x0 > y0);
    j1 = !i1;
    u24 = longint'(sn2d_pkg::UnskewQ24);
    x1 = x0 - (i1 ? longint'(sn2d_pkg::OneQ24) : 0) + u24;
    y1 = y0 - (j1 ? longint'(sn2d_pkg::OneQ24) : 0) + u24;
    x2 = x0 - longint'(sn2d_pkg::OneQ24) + 2 * u24;
    y2 = y0 - longint'(sn2d_pkg::OneQ24) + 2 * u24;
    pi = i[7:0];
    pj = j[7:0];
    g0 = perm_mem[8'(pi + perm_mem[pj])];
    g1 = perm_mem[8'(pi + 8'(i1) + perm_mem[8'(pj + 8'(j1))])];
    g2 = perm_mem[8'(pi + 8'd1 + perm_mem[8'(pj + 8'd1)])];
    sum = corner_term(g0, x0, y0) + corner_term(g1, x1, y1) + corner_term(g2, x2, y2);
    v = floor_shr(sum * 70 + (longint'(1) <<< 32), 33);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  // Predict on input transfers and compare on output transfers.
  always @(posedge clk_i) begin
    logic signed [15:0] want;
    if (!rst_ni) begin
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        case (sn2d_pkg::action_e'(in_i.action))
          sn2d_pkg::ActEval:     noise_q.push_back(noise_at(in_i.x_coord, in_i.y_coord));
          sn2d_pkg::ActLoadPerm: perm_mem[in_i.table_index] = in_i.perm_value;
          sn2d_pkg::ActLoadGrad: grad_mem[in_i.table_index] = {in_i.grad_y, in_i.grad_x};
          default: ;
        endcase
      end
      if (out_i.valid && out_i.ready) begin
        if (noise_q.size() == 0) begin
          fail_count_o <= fail_count_o + 1;
          if (fail_count_o < 10) $display("unexpected noise value %0d", out_i.noise_value);
        end else begin
          want = noise_q.pop_front();
          if (want !== out_i.noise_value) begin
            fail_count_o <= fail_count_o + 1;
            if (fail_count_o < 10)
              $display("noise_value mismatch: expected %0d, got %0d", want,
                       out_i.noise_value);
          end
        end
      end
      pending_o <= noise_q.size();
    end
  end
endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus for the simplex noise block: loads the permutation table and the
// gradient entries that it points at, then sends directed and random
// evaluates and reloads under varied handshake idling.
// ----------------------------------------------------------------------------
module tb;
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count, pending;
  int   idle_cycles = 0;
  int   send_idle_pct = 7, recv_idle_pct = 64;
  bit   hold_off = 1'b0;

  sn2d_in_if  in_ch ();
  sn2d_out_if out_ch ();

  simplex_noise_2d_top DUT (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch), .out_o(out_ch));
  tb_noise_checker u_checker (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch), .out_i(out_ch),
                              .fail_count_o(fail_count), .pending_o(pending));

  always #1 clk_i = ~clk_i;

  // The receiver stalls at random, or for a long stretch while held off.
  always @(posedge clk_i) begin
    out_ch.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // Offer one item, with a random gap first, and wait for its transfer.
  task automatic send_item(sn2d_pkg::action_e act, logic [31:0] x, logic [31:0] y,
                           logic [7:0] idx, logic [7:0] pv, logic [15:0] gx,
                           logic [15:0] gy);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.x_coord <= x;
    in_ch.y_coord <= y;
    in_ch.table_index <= idx;
    in_ch.perm_value <= pv;
    in_ch.grad_x <= gx;
    in_ch.grad_y <= gy;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // Permutation values stay below 64, so only the loaded gradient entries are read.
  task automatic random_items(int count);
    int r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      if (r < 75)
        send_item(sn2d_pkg::ActEval, (r < 40) ? $urandom_range(32'h00FF_FFFF) : $urandom(),
                  (r < 40) ? $urandom_range(32'h00FF_FFFF) : $urandom(), 8'($urandom()),
                  8'($urandom()), 16'($urandom()), 16'($urandom()));
      else if (r < 85)
        send_item(sn2d_pkg::ActLoadPerm, $urandom(), $urandom(), 8'($urandom()),
                  8'($urandom_range(63)), 16'($urandom()), 16'($urandom()));
      else if (r < 95)
        send_item(sn2d_pkg::ActLoadGrad, $urandom(), $urandom(), 8'($urandom()),
                  8'($urandom()), 16'($urandom()), 16'($urandom()));
      else
        send_item(sn2d_pkg::ActNone, $urandom(), $urandom(), 8'($urandom()),
                  8'($urandom()), 16'($urandom()), 16'($urandom()));
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.action = sn2d_pkg::ActNone;
    in_ch.x_coord = '0;
    in_ch.y_coord = '0;
    in_ch.table_index = '0;
    in_ch.perm_value = '0;
    in_ch.grad_x = '0;
    in_ch.grad_y = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill the permutation table with values below 64 and the gradient
    // entries that those values select, so no evaluate reads an unwritten entry.
    for (int k = 0; k < 256; k++)
      send_item(sn2d_pkg::ActLoadPerm, '0, '0, 8'(k), 8'(6'(k * 37 + 11)), '0, '0);
    for (int k = 0; k < 64; k++)
      send_item(sn2d_pkg::ActLoadGrad, '0, '0, 8'(k), '0, 16'($urandom()), 16'($urandom()));
    // Extreme gradients, so saturation at plus and minus one is reachable.
    send_item(sn2d_pkg::ActLoadGrad, '0, '0, 8'd0, '0, 16'h7FFF, 16'h7FFF);
    send_item(sn2d_pkg::ActLoadGrad, '0, '0, 8'd63, '0, 16'h8000, 16'h8000);

    // Directed evaluates: corners of the coordinate range and cell edges.
    send_item(sn2d_pkg::ActEval, 32'h0, 32'h0, '0, '0, '0, '0);
    send_item(sn2d_pkg::ActEval, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, '0, '0, '0);
    send_item(sn2d_pkg::ActEval, 32'hFFFF_FFFF, 32'h0, '0, '0, '0, '0);
    send_item(sn2d_pkg::ActEval, 32'h0, 32'hFFFF_FFFF, '0, '0, '0, '0);
    send_item(sn2d_pkg::ActEval, 32'h0000_4000, 32'h0000_2000, '0, '0, '0, '0);
    send_item(sn2d_pkg::ActEval, 32'h0000_2000, 32'h0000_4000, '0, '0, '0, '0);
    send_item(sn2d_pkg::ActEval, 32'h0000_8000, 32'h0000_8000, '0, '0, '0, '0);
    send_item(sn2d_pkg::ActEval, 32'h00FF_8000, 32'h00FF_C000, '0, '0, '0, '0);
    send_item(sn2d_pkg::ActNone, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 16'hFFFF,
              16'hFFFF);
    for (int k = 0; k < 6; k++)
      send_item(sn2d_pkg::ActEval, $urandom_range(32'h0002_0000),
                $urandom_range(32'h0002_0000), '0, '0, '0, '0);

    random_items(40);
    send_idle_pct = 64;
    recv_idle_pct = 7;
    random_items(40);

    // Long hold-off at the receiver while items keep coming.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off = 1'b1;
    fork
      begin
        repeat (200) @(posedge clk_i);
        hold_off = 1'b0;
      end
      random_items(40);
    join
    in_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end
endmodule
